FILE: hdl/argument_fetch_line_splitter_assert.svh
// Assertion macros used by the line splitter back end.
`ifndef ARGUMENT_FETCH_LINE_SPLITTER_ASSERT_SVH
`define ARGUMENT_FETCH_LINE_SPLITTER_ASSERT_SVH

// Antecedent implies consequent in the same cycle.
`define AFLS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the next cycle.
`define AFLS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/afls_pkg.sv
// Package with constants and types of the argument fetch line splitter.
`default_nettype none
package afls_pkg;

  localparam int LINE_BYTES  = 64;   // power of two, 8 to 64
  localparam int BUF_BYTES   = 1024;
  localparam int ADDR_W      = 64;
  localparam int SIZE_IN_W   = 32;
  localparam int TGT_W       = 16;
  localparam int REQ_BYTES_W = 7;

  localparam int SZ_W   = $clog2(BUF_BYTES + 1);
  localparam int LN_W   = $clog2(LINE_BYTES + 1);
  localparam int LOFS_W = $clog2(LINE_BYTES);
  localparam int CW     = (SZ_W > LN_W) ? SZ_W : LN_W;

  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  // A command after clamping, as it waits in the queue.
  typedef struct packed {
    logic [ADDR_W-1:0] base0;
    logic [SZ_W-1:0]   size0;
    logic [ADDR_W-1:0] base1;
    logic [SZ_W-1:0]   size1;
    logic [TGT_W-1:0]  target;
  } cmd_t;

  // Queue status seen by the front and the back.
  typedef struct packed {
    logic full;
    logic nonempty;
  } q_stat_t;

endpackage
`default_nettype wire

FILE: hdl/afls_if.sv
// Channel interfaces for commands and read requests.
`default_nettype none
interface afls_in_if
  import afls_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [ADDR_W-1:0]    region1_base;
  logic [SIZE_IN_W-1:0] region1_bytes;
  logic [ADDR_W-1:0]    region2_base;
  logic [SIZE_IN_W-1:0] region2_bytes;
  logic [TGT_W-1:0]     peer_device;

  modport source (output valid, region1_base, region1_bytes, region2_base,
                  region2_bytes, peer_device, input ready);
  modport sink   (input valid, region1_base, region1_bytes, region2_base,
                  region2_bytes, peer_device, output ready);
endinterface

interface afls_out_if
  import afls_pkg::*;
;
  logic                   valid;
  logic                   ready;
  logic [ADDR_W-1:0]      req_address;
  logic [REQ_BYTES_W-1:0] req_bytes;
  logic                   req_region;
  logic [TGT_W-1:0]       req_target;
  logic                   issue;
  logic                   last;

  modport source (output valid, req_address, req_bytes, req_region, req_target,
                  issue, last, input ready);
  modport sink   (input valid, req_address, req_bytes, req_region, req_target,
                  issue, last, output ready);
endinterface
`default_nettype wire

FILE: hdl/afls_queue.sv
// Short command queue between the front and the back.
`default_nettype none
module afls_queue
  import afls_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    push,
  input  wire cmd_t    push_cmd,
  input  wire logic    pop,
  output cmd_t         head_cmd,
  output q_stat_t      stat
);

  cmd_t            mem [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CW-1:0] count_r, count_nxt;
  logic            do_push, do_pop;

  assign do_push = push && (count_r != Q_CW'(Q_DEPTH));
  assign do_pop  = pop && (count_r != '0);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_cmd;
    end
  end

  assign head_cmd      = mem[rd_ptr_r];
  assign stat.full     = (count_r == Q_CW'(Q_DEPTH));
  assign stat.nonempty = (count_r != '0);

endmodule
`default_nettype wire

FILE: hdl/afls_front.sv
// Command front end: accepts commands and clamps the region sizes.
`default_nettype none
module afls_front
  import afls_pkg::*;
(
  afls_in_if.sink   in_ch,
  input  wire q_stat_t stat,
  output logic      push,
  output cmd_t      push_cmd
);

  function automatic logic [SZ_W-1:0] clamp(input logic [SIZE_IN_W-1:0] v);
    if (v > SIZE_IN_W'(BUF_BYTES)) begin
      return SZ_W'(BUF_BYTES);
    end
    return SZ_W'(v);
  endfunction

  assign in_ch.ready = !stat.full;
  assign push        = in_ch.valid && !stat.full;

  always_comb begin
    push_cmd.base0  = in_ch.region1_base;
    push_cmd.size0  = clamp(in_ch.region1_bytes);
    push_cmd.base1  = in_ch.region2_base;
    push_cmd.size1  = clamp(in_ch.region2_bytes);
    push_cmd.target = in_ch.peer_device;
  end

endmodule
`default_nettype wire

FILE: hdl/afls_back.sv
// Region walker: splits each queued command into line-bounded read requests.
`default_nettype none
module afls_back
  import afls_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire cmd_t    head_cmd,
  input  wire q_stat_t stat,
  output logic         pop,
  afls_out_if.source   out_ch
);

  `include "argument_fetch_line_splitter_assert.svh"

  localparam int CHK_W = CW + 1;

  cmd_t                   cmd_r;
  logic                   busy_r, busy_nxt;
  logic                   region_r, region_nxt;
  logic [SZ_W-1:0]        offset_r, offset_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic [ADDR_W-1:0]      out_addr_r;
  logic [REQ_BYTES_W-1:0] out_bytes_r;
  logic                   out_region_r;
  logic [TGT_W-1:0]       out_target_r;
  logic                   out_issue_r;
  logic                   out_last_r;

  logic                   emit, load, cmd_empty, end_reg, last;
  logic [ADDR_W-1:0]      cur_base, addr;
  logic [SZ_W-1:0]        total;
  logic [CW-1:0]          to_edge, left, n, offs_sum;

  assign load      = !busy_r && stat.nonempty;
  assign pop       = load;
  assign emit      = busy_r && (!out_valid_r || out_ch.ready);
  assign cmd_empty = (cmd_r.size0 == '0) && (cmd_r.size1 == '0);

  always_comb begin
    cur_base = region_r ? cmd_r.base1 : cmd_r.base0;
    total    = region_r ? cmd_r.size1 : cmd_r.size0;
    addr     = cur_base + ADDR_W'(offset_r);
    // Bytes to the next line boundary, at most one whole line.
    to_edge  = CW'(LINE_BYTES) - CW'(addr[LOFS_W-1:0]);
    left     = CW'(total) - CW'(offset_r);
    n        = (left < to_edge) ? left : to_edge;
    offs_sum = CW'(offset_r) + n;
    end_reg  = (offs_sum == CW'(total));
    last     = cmd_empty || (end_reg && (region_r || (cmd_r.size1 == '0)));
  end

  always_comb begin
    busy_nxt   = busy_r;
    region_nxt = region_r;
    offset_nxt = offset_r;
    if (load) begin
      busy_nxt   = 1'b1;
      // An empty first region is skipped straight away.
      region_nxt = (head_cmd.size0 == '0) && (head_cmd.size1 != '0);
      offset_nxt = '0;
    end else if (emit) begin
      busy_nxt   = !last;
      region_nxt = end_reg ? 1'b1 : region_r;
      offset_nxt = end_reg ? '0 : SZ_W'(offs_sum);
    end
    out_valid_nxt = emit ? 1'b1 : (out_valid_r && !out_ch.ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      region_r    <= 1'b0;
      offset_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      region_r    <= region_nxt;
      offset_r    <= offset_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cmd_r <= head_cmd;
    end
    if (emit) begin
      out_target_r <= cmd_r.target;
      out_last_r   <= last;
      if (cmd_empty) begin
        out_addr_r   <= '0;
        out_bytes_r  <= '0;
        out_region_r <= 1'b0;
        out_issue_r  <= 1'b0;
      end else begin
        out_addr_r   <= addr;
        out_bytes_r  <= REQ_BYTES_W'(n);
        out_region_r <= region_r;
        out_issue_r  <= 1'b1;
      end
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.req_address = out_addr_r;
  assign out_ch.req_bytes   = out_bytes_r;
  assign out_ch.req_region  = out_region_r;
  assign out_ch.req_target  = out_target_r;
  assign out_ch.issue       = out_issue_r;
  assign out_ch.last        = out_last_r;

  `AFLS_ASSERT_IMPL(a_offset_in_region, busy_r && !cmd_empty, offset_r < total,
                    "offset past region end")
  `AFLS_ASSERT_IMPL(a_no_line_cross, emit && !cmd_empty,
                    (CHK_W'(addr[LOFS_W-1:0]) + CHK_W'(n)) <= CHK_W'(LINE_BYTES),
                    "request crosses a line")
  `AFLS_ASSERT_NEXT(a_last_frees, emit && last, !busy_r && out_valid_r && out_last_r,
                    "last result did not end the walk")

endmodule
`default_nettype wire

FILE: hdl/argument_fetch_line_splitter.sv
// Top level of the argument fetch line splitter.
//
//   channel   direction  carries
//   in_ch     in         command: two regions (base, bytes) and a peer device
//   out_ch    out        read request: address, bytes, region, target, issue, last
//
// The back end emits one result per cycle while the output is not stalled, and
// loads a new command from the queue only after the last result of the one before.
// At the default sizes a command yields up to 17 line pieces per misaligned
// 1024-byte region, or one empty marker.
// Reset is synchronous and active low; it empties the queue and idles the walker.
// A stalled output holds its item while the two-entry queue takes commands until full.
`default_nettype none
module argument_fetch_line_splitter
  import afls_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  afls_in_if.sink    in_ch,
  afls_out_if.source out_ch
);

  logic    push, pop;
  cmd_t    push_cmd, head_cmd;
  q_stat_t stat;

  afls_front u_front (
    .in_ch    (in_ch),
    .stat     (stat),
    .push     (push),
    .push_cmd (push_cmd)
  );

  afls_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head_cmd (head_cmd),
    .stat     (stat)
  );

  afls_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head_cmd (head_cmd),
    .stat     (stat),
    .pop      (pop),
    .out_ch   (out_ch)
  );

endmodule
`default_nettype wire
